### rtl/khsm_pkg.sv
// ---------------------------------------------------------------------------
// khsm_pkg: shared types, constants and hash functions
// Word layouts, back-end state codes and the SuperFastHash round,
// tail and avalanche functions used by the key hash shard mapper.
// ---------------------------------------------------------------------------
package khsm_pkg;

   localparam int unsigned HASH_W              = 32;
   localparam int unsigned KEY_LEN_W           = 8;
   localparam int unsigned CHUNK_BYTES_W       = 3;
   localparam int unsigned CPU_W               = 7;
   localparam int unsigned SLICE_W             = 11;
   localparam int unsigned CPU_IDX_W           = 6;
   localparam int unsigned SLICE_IDX_W         = 10;
   localparam int unsigned CPU_COUNT_MAX       = 64;
   localparam int unsigned SLICE_COUNT_MAX     = 1024;
   localparam int unsigned DIVIDEND_W          = HASH_W;
   localparam int unsigned DIVISOR_W           = SLICE_W;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned CSR_ADDR_W          = 3;
   localparam int unsigned CSR_DATA_W          = 32;
   localparam int unsigned CSR_IDX_BIT         = 2;

   localparam logic REG_CPU_COUNT   = 1'b0;
   localparam logic REG_SLICE_COUNT = 1'b1;

   localparam logic [CHUNK_BYTES_W-1:0] CHUNK_NONE  = 3'd0;
   localparam logic [CHUNK_BYTES_W-1:0] CHUNK_ONE   = 3'd1;
   localparam logic [CHUNK_BYTES_W-1:0] CHUNK_TWO   = 3'd2;
   localparam logic [CHUNK_BYTES_W-1:0] CHUNK_THREE = 3'd3;
   localparam logic [CHUNK_BYTES_W-1:0] CHUNK_FULL  = 3'd4;

   typedef struct packed {
      logic                     first_chunk;
      logic                     last_chunk;
      logic [KEY_LEN_W-1:0]     key_length;
      logic [HASH_W-1:0]        chunk_data;
      logic [CHUNK_BYTES_W-1:0] chunk_bytes;
   } req_word_type;

   typedef struct packed {
      logic [HASH_W-1:0]      hash_value;
      logic [CPU_IDX_W-1:0]   cpu_index;
      logic [SLICE_IDX_W-1:0] slice_index;
   } rsp_word_type;

   typedef struct packed {
      logic [HASH_W-1:0] pre_hash;
      logic              key_empty;
   } hash_job_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  busy;
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_AVAL_A,
      BK_AVAL_B,
      BK_CPU_GO,
      BK_CPU_WAIT,
      BK_SLICE_GO,
      BK_SLICE_WAIT,
      BK_SEND
   } back_state_type;

   function automatic logic [HASH_W-1:0] sext8(input logic [7:0] b);
      return {{(HASH_W-8){b[7]}}, b};
   endfunction

   function automatic logic [HASH_W-1:0] mix_chunk(input logic [HASH_W-1:0]        h,
                                                   input logic [HASH_W-1:0]        d,
                                                   input logic [CHUNK_BYTES_W-1:0] n);
      logic [HASH_W-1:0]        lo;
      logic [HASH_W-1:0]        t;
      logic [HASH_W-1:0]        x;
      logic [CHUNK_BYTES_W-1:0] nb;
      lo = {16'h0000, d[15:0]};
      nb = (n > CHUNK_FULL) ? CHUNK_FULL : n;
      x  = h;
      t  = '0;
      case (nb)
         CHUNK_FULL: begin
            x = h + lo;
            t = {5'b0, d[31:16], 11'b0} ^ x;
            x = {x[15:0], 16'h0000} ^ t;
            x = x + (x >> 11);
         end
         CHUNK_THREE: begin
            x = h + lo;
            x = x ^ (x << 16);
            x = x ^ (sext8(d[23:16]) << 18);
            x = x + (x >> 11);
         end
         CHUNK_TWO: begin
            x = h + lo;
            x = x ^ (x << 11);
            x = x + (x >> 17);
         end
         CHUNK_ONE: begin
            x = h + sext8(d[7:0]);
            x = x ^ (x << 10);
            x = x + (x >> 1);
         end
         default: begin
            x = h;
         end
      endcase
      return x;
   endfunction

   function automatic logic [HASH_W-1:0] aval_front(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] x;
      x = h ^ (h << 3);
      x = x + (x >> 5);
      x = x ^ (x << 4);
      return x;
   endfunction

   function automatic logic [HASH_W-1:0] aval_back(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] x;
      x = h + (h >> 17);
      x = x ^ (x << 25);
      x = x + (x >> 6);
      return x;
   endfunction

endpackage

### rtl/khsm_front.sv
// ---------------------------------------------------------------------------
// khsm_front: chunk intake and hash rounds
// Accepts key chunks, runs one hash round per chunk and hands the
// pre-avalanche hash of each finished key to the job queue.
// ---------------------------------------------------------------------------
module khsm_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  khsm_pkg::req_word_type req_word,
   input  logic                  queue_full,
   output logic                  job_push,
   output khsm_pkg::hash_job_type job_word
);

   logic [khsm_pkg::HASH_W-1:0] running_hash_ff;
   logic [khsm_pkg::HASH_W-1:0] running_hash_in;
   logic                        key_empty_ff;
   logic                        key_empty_in;
   logic [khsm_pkg::HASH_W-1:0] seed_hash;
   logic                        seed_empty;
   logic [khsm_pkg::HASH_W-1:0] mixed_hash;
   logic                        accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      seed_hash  = req_word.first_chunk ?
                   {{(khsm_pkg::HASH_W-khsm_pkg::KEY_LEN_W){1'b0}}, req_word.key_length} :
                   running_hash_ff;
      seed_empty = req_word.first_chunk ? (req_word.key_length == '0) : key_empty_ff;
      mixed_hash = seed_empty ? seed_hash :
                   khsm_pkg::mix_chunk(seed_hash, req_word.chunk_data, req_word.chunk_bytes);
   end

   always_comb begin
      running_hash_in = running_hash_ff;
      key_empty_in    = key_empty_ff;
      if (accept) begin
         running_hash_in = mixed_hash;
         key_empty_in    = seed_empty;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_hash_ff <= '0;
         key_empty_ff    <= 1'b0;
      end else begin
         running_hash_ff <= running_hash_in;
         key_empty_ff    <= key_empty_in;
      end
   end

   assign job_push           = accept && req_word.last_chunk;
   assign job_word.pre_hash  = mixed_hash;
   assign job_word.key_empty = seed_empty;

endmodule

### rtl/khsm_fifo.sv
// ---------------------------------------------------------------------------
// khsm_fifo: finished-key job queue
// Small register queue that decouples chunk intake from the
// avalanche and shard division back end.
// ---------------------------------------------------------------------------
module khsm_fifo #(
   parameter int unsigned DEPTH = khsm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  khsm_pkg::hash_job_type push_word,
   output logic                   full,
   input  logic                   pop,
   output khsm_pkg::hash_job_type pop_word,
   output logic                   empty
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   khsm_pkg::hash_job_type entry_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

### rtl/khsm_div.sv
// ---------------------------------------------------------------------------
// khsm_div: iterative restoring divider
// Unsigned 32-bit by 11-bit division, one quotient bit per cycle,
// shared by the cpu and slice index computations.
// ---------------------------------------------------------------------------
module khsm_div (
   input  logic                  clock,
   input  logic                  reset,
   input  khsm_pkg::div_req_type div_req,
   output khsm_pkg::div_rsp_type div_rsp
);

   localparam int unsigned QW     = khsm_pkg::DIVIDEND_W;
   localparam int unsigned RW     = khsm_pkg::DIVISOR_W;
   localparam int unsigned STEP_W = $clog2(QW);

   logic              busy_ff;
   logic              busy_in;
   logic              done_ff;
   logic              done_in;
   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic [QW-1:0]     quo_ff;
   logic [QW-1:0]     quo_in;
   logic [RW-1:0]     rem_ff;
   logic [RW-1:0]     rem_in;
   logic [RW-1:0]     divisor_ff;
   logic [RW-1:0]     divisor_in;
   logic [RW-1:0]     trial;
   logic              fits;

   // remainder stays below the divisor, so its top bit is always clear
   assign trial = {rem_ff[RW-2:0], quo_ff[QW-1]};
   assign fits  = (trial >= divisor_ff);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (div_req.start && !busy_ff) begin
         busy_in    = 1'b1;
         step_in    = '0;
         quo_in     = div_req.dividend;
         rem_in     = '0;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[QW-2:0], fits};
         rem_in  = fits ? (trial - divisor_ff) : trial;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.busy      = busy_ff;
   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

### rtl/khsm_back.sv
// ---------------------------------------------------------------------------
// khsm_back: avalanche and shard selection
// Pops finished keys, applies the avalanche in two steps, derives the
// cpu and slice indices with the shared divider and holds the result word.
// ---------------------------------------------------------------------------
module khsm_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [khsm_pkg::CPU_W-1:0]      cpu_count,
   input  logic [khsm_pkg::SLICE_W-1:0]    slice_count,
   input  logic                            job_valid,
   input  khsm_pkg::hash_job_type          job_word,
   output logic                            job_pop,
   output khsm_pkg::div_req_type           div_req,
   input  khsm_pkg::div_rsp_type           div_rsp,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output khsm_pkg::rsp_word_type          rsp_word
);

   khsm_pkg::back_state_type state_ff;
   khsm_pkg::back_state_type state_in;

   logic [khsm_pkg::HASH_W-1:0]      hash_ff;
   logic [khsm_pkg::HASH_W-1:0]      hash_in;
   logic                             empty_ff;
   logic                             empty_in;
   logic [khsm_pkg::HASH_W-1:0]      quot_ff;
   logic [khsm_pkg::HASH_W-1:0]      quot_in;
   logic [khsm_pkg::CPU_IDX_W-1:0]   cpu_idx_ff;
   logic [khsm_pkg::CPU_IDX_W-1:0]   cpu_idx_in;
   logic [khsm_pkg::SLICE_IDX_W-1:0] slice_idx_ff;
   logic [khsm_pkg::SLICE_IDX_W-1:0] slice_idx_in;
   logic [khsm_pkg::CPU_W-1:0]       cpu_eff;
   logic [khsm_pkg::SLICE_W-1:0]     slice_eff;

   always_comb begin
      if (cpu_count == '0) begin
         cpu_eff = khsm_pkg::CPU_W'(1);
      end else if (cpu_count > khsm_pkg::CPU_W'(khsm_pkg::CPU_COUNT_MAX)) begin
         cpu_eff = khsm_pkg::CPU_W'(khsm_pkg::CPU_COUNT_MAX);
      end else begin
         cpu_eff = cpu_count;
      end
      if (slice_count == '0) begin
         slice_eff = khsm_pkg::SLICE_W'(1);
      end else if (slice_count > khsm_pkg::SLICE_W'(khsm_pkg::SLICE_COUNT_MAX)) begin
         slice_eff = khsm_pkg::SLICE_W'(khsm_pkg::SLICE_COUNT_MAX);
      end else begin
         slice_eff = slice_count;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         khsm_pkg::BK_IDLE: begin
            if (job_valid) begin
               state_in = khsm_pkg::BK_AVAL_A;
            end
         end
         khsm_pkg::BK_AVAL_A: begin
            state_in = khsm_pkg::BK_AVAL_B;
         end
         khsm_pkg::BK_AVAL_B: begin
            state_in = khsm_pkg::BK_CPU_GO;
         end
         khsm_pkg::BK_CPU_GO: begin
            state_in = khsm_pkg::BK_CPU_WAIT;
         end
         khsm_pkg::BK_CPU_WAIT: begin
            if (div_rsp.done) begin
               state_in = khsm_pkg::BK_SLICE_GO;
            end
         end
         khsm_pkg::BK_SLICE_GO: begin
            state_in = khsm_pkg::BK_SLICE_WAIT;
         end
         khsm_pkg::BK_SLICE_WAIT: begin
            if (div_rsp.done) begin
               state_in = khsm_pkg::BK_SEND;
            end
         end
         khsm_pkg::BK_SEND: begin
            if (rsp_ready) begin
               state_in = khsm_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = khsm_pkg::BK_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      job_pop          = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = hash_ff;
      div_req.divisor  = {{(khsm_pkg::SLICE_W-khsm_pkg::CPU_W){1'b0}}, cpu_eff};
      rsp_valid        = 1'b0;
      case (state_ff)
         khsm_pkg::BK_IDLE: begin
            job_pop = job_valid;
         end
         khsm_pkg::BK_CPU_GO: begin
            div_req.start = 1'b1;
         end
         khsm_pkg::BK_SLICE_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = quot_ff;
            div_req.divisor  = slice_eff;
         end
         khsm_pkg::BK_SEND: begin
            rsp_valid = 1'b1;
         end
         default: begin
            job_pop = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      hash_in      = hash_ff;
      empty_in     = empty_ff;
      quot_in      = quot_ff;
      cpu_idx_in   = cpu_idx_ff;
      slice_idx_in = slice_idx_ff;
      if (state_ff == khsm_pkg::BK_IDLE && job_valid) begin
         hash_in  = job_word.pre_hash;
         empty_in = job_word.key_empty;
      end
      if (state_ff == khsm_pkg::BK_AVAL_A) begin
         hash_in = khsm_pkg::aval_front(hash_ff);
      end
      if (state_ff == khsm_pkg::BK_AVAL_B) begin
         hash_in = empty_ff ? '0 : khsm_pkg::aval_back(hash_ff);
      end
      if (state_ff == khsm_pkg::BK_CPU_WAIT && div_rsp.done) begin
         quot_in    = div_rsp.quotient;
         cpu_idx_in = div_rsp.remainder[khsm_pkg::CPU_IDX_W-1:0];
      end
      if (state_ff == khsm_pkg::BK_SLICE_WAIT && div_rsp.done) begin
         slice_idx_in = div_rsp.remainder[khsm_pkg::SLICE_IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= khsm_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      hash_ff      <= hash_in;
      empty_ff     <= empty_in;
      quot_ff      <= quot_in;
      cpu_idx_ff   <= cpu_idx_in;
      slice_idx_ff <= slice_idx_in;
   end

   assign rsp_word.hash_value  = hash_ff;
   assign rsp_word.cpu_index   = cpu_idx_ff;
   assign rsp_word.slice_index = slice_idx_ff;

   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");

   a_send_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == khsm_pkg::BK_SEND && !rsp_ready) |=>
         (state_ff == khsm_pkg::BK_SEND && $stable(rsp_word)))
      else $error("result word changed while stalled");

   a_cpu_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, cpu_idx_ff} < cpu_eff))
      else $error("cpu index out of range");

   a_slice_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, slice_idx_ff} < slice_eff))
      else $error("slice index out of range");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && empty_ff) |-> (hash_ff == '0))
      else $error("empty key gave nonzero hash");

endmodule

### rtl/key_hash_shard_mapper.sv
// ---------------------------------------------------------------------------
// key_hash_shard_mapper: SuperFastHash key to cpu/slice shard mapper
// Keys arrive as 4-byte chunk words on req_*; the first chunk carries the
// key length that seeds the hash. One result word per key leaves on rsp_*
// with the hash, hash mod cpu_count and (hash div cpu_count) mod slice_count.
// Register 0 (cpu_count) at byte 0, register 1 (slice_count) at byte 4 on
// the csr_* port; write only while no key is in flight.
// Throughput: the front end takes one chunk word per cycle while the job
// queue has room and runs a hash round on it in the same cycle. Finished
// keys wait in a QUEUE_DEPTH-entry job queue. The back end runs the
// avalanche and then two restoring divisions per key, cpu first and slice
// second, and can take the next key in the cycle after its word is taken.
// For short keys the divider sets the sustained rate, as no new key starts
// until the last result word is taken; long keys run at one chunk per
// cycle. When rsp_ready is low the result word holds, the back end stops
// and req keeps flowing until the job queue is full. Reset empties the
// queue, clears the running hash and sets both counts to 1.
// ---------------------------------------------------------------------------
module key_hash_shard_mapper #(
   parameter int unsigned QUEUE_DEPTH = khsm_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  khsm_pkg::req_word_type             req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output khsm_pkg::rsp_word_type             rsp_word,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [khsm_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [khsm_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [khsm_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);

   logic [khsm_pkg::CPU_W-1:0]   cpu_count_ff;
   logic [khsm_pkg::CPU_W-1:0]   cpu_count_in;
   logic [khsm_pkg::SLICE_W-1:0] slice_count_ff;
   logic [khsm_pkg::SLICE_W-1:0] slice_count_in;
   logic                         csr_write;
   logic                         reg_sel;

   logic                   queue_full;
   logic                   queue_empty;
   logic                   job_push;
   logic                   job_pop;
   khsm_pkg::hash_job_type push_word;
   khsm_pkg::hash_job_type pop_word;
   khsm_pkg::div_req_type  div_req;
   khsm_pkg::div_rsp_type  div_rsp;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[khsm_pkg::CSR_IDX_BIT];

   always_comb begin
      cpu_count_in   = cpu_count_ff;
      slice_count_in = slice_count_ff;
      if (csr_write && reg_sel == khsm_pkg::REG_CPU_COUNT) begin
         cpu_count_in = csr_pwdata[khsm_pkg::CPU_W-1:0];
      end
      if (csr_write && reg_sel == khsm_pkg::REG_SLICE_COUNT) begin
         slice_count_in = csr_pwdata[khsm_pkg::SLICE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_count_ff   <= khsm_pkg::CPU_W'(1);
         slice_count_ff <= khsm_pkg::SLICE_W'(1);
      end else begin
         cpu_count_ff   <= cpu_count_in;
         slice_count_ff <= slice_count_in;
      end
   end

   always_comb begin
      if (reg_sel == khsm_pkg::REG_SLICE_COUNT) begin
         csr_prdata = {{(khsm_pkg::CSR_DATA_W-khsm_pkg::SLICE_W){1'b0}}, slice_count_ff};
      end else begin
         csr_prdata = {{(khsm_pkg::CSR_DATA_W-khsm_pkg::CPU_W){1'b0}}, cpu_count_ff};
      end
   end

   khsm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_word   (req_word),
      .queue_full (queue_full),
      .job_push   (job_push),
      .job_word   (push_word)
   );

   khsm_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_word (push_word),
      .full      (queue_full),
      .pop       (job_pop),
      .pop_word  (pop_word),
      .empty     (queue_empty)
   );

   khsm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   khsm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cpu_count   (cpu_count_ff),
      .slice_count (slice_count_ff),
      .job_valid   (!queue_empty),
      .job_word    (pop_word),
      .job_pop     (job_pop),
      .div_req     (div_req),
      .div_rsp     (div_rsp),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for key_hash_shard_mapper
// Feeds keys as chunk words: a directed table of corner cases first, then
// random keys under six cpu/slice count settings, with random idling on
// both sides. Each result word is compared field by field with a local
// model of the hash and the shard choice.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import khsm_pkg::*;

   localparam int QUIET_LIMIT     = 3000;
   localparam int SETTLE_CYCLES   = 80;
   localparam int PHASES          = 6;
   localparam int PHASE_WORDS     = 67;
   localparam int N_PROBES        = 24;
   localparam int MAX_KEY_LEN     = 255;

   typedef struct packed {
      logic                     first;
      logic                     last;
      logic [KEY_LEN_W-1:0]     len;
      logic [HASH_W-1:0]        data;
      logic [CHUNK_BYTES_W-1:0] nbytes;
      logic                     typed;
      logic [HASH_W-1:0]        hash;
      logic [CPU_IDX_W-1:0]     cpu;
      logic [SLICE_IDX_W-1:0]   slice;
   } probe_row_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_ready;
   req_word_type           req_word    = '0;
   logic                   rsp_valid;
   logic                   rsp_ready   = 1'b0;
   rsp_word_type           rsp_word;
   logic                   csr_psel    = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // shadow of the block's state and count registers
   logic [HASH_W-1:0]      key_hash     = '0;
   logic                   key_is_empty = 1'b0;
   logic [CPU_W-1:0]       cfg_cpu      = 7'd1;
   logic [SLICE_W-1:0]     cfg_slice    = 11'd1;

   rsp_word_type           pending_shards[$];
   int                     error_count  = 0;
   int                     quiet_cycles = 0;
   int                     send_gap_pct = 0;
   int                     rsp_gap_pct  = 0;

   probe_row_type probe_rows [N_PROBES] = '{
      // chunk with no first chunk after reset
      '{1'b0, 1'b1, 8'hA5, 32'h1234_5678, CHUNK_FULL,  1'b0, 32'h0, 6'd0, 10'd0},
      // empty keys
      '{1'b1, 1'b1, 8'd0,  32'hFFFF_FFFF, CHUNK_FULL,  1'b1, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b0, 8'd0,  32'hAAAA_5555, CHUNK_FULL,  1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b0, 1'b1, 8'hFF, 32'h5555_AAAA, CHUNK_THREE, 1'b1, 32'h0, 6'd0, 10'd0},
      // one to four byte keys, lone bytes of both signs
      '{1'b1, 1'b1, 8'd1,  32'h0000_007F, CHUNK_ONE,   1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b1, 8'd1,  32'hFFFF_FF80, CHUNK_ONE,   1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b1, 8'd2,  32'h0000_FFFF, CHUNK_TWO,   1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b1, 8'd3,  32'h007F_FFFF, CHUNK_THREE, 1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b1, 8'd3,  32'hFF80_0000, CHUNK_THREE, 1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b1, 8'd4,  32'hFFFF_FFFF, CHUNK_FULL,  1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b1, 8'd4,  32'h0000_0000, CHUNK_FULL,  1'b0, 32'h0, 6'd0, 10'd0},
      // zero-byte last chunk
      '{1'b1, 1'b0, 8'd5,  32'hDEAD_BEEF, CHUNK_FULL,  1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b0, 1'b1, 8'h00, 32'h0000_0000, CHUNK_NONE,  1'b0, 32'h0, 6'd0, 10'd0},
      // byte counts above four
      '{1'b1, 1'b1, 8'hFF, 32'h8765_4321, 3'd5,        1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b1, 8'hFF, 32'h0F0F_F0F0, 3'd7,        1'b0, 32'h0, 6'd0, 10'd0},
      // length and chunks disagree
      '{1'b1, 1'b1, 8'hFF, 32'h0000_1234, CHUNK_TWO,   1'b0, 32'h0, 6'd0, 10'd0},
      // partial chunk before the last
      '{1'b1, 1'b0, 8'd6,  32'h0000_BEEF, CHUNK_TWO,   1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b0, 1'b1, 8'd6,  32'hCAFE_F00D, CHUNK_FULL,  1'b0, 32'h0, 6'd0, 10'd0},
      // new first chunk in the middle of a key
      '{1'b1, 1'b0, 8'd8,  32'h1111_1111, CHUNK_FULL,  1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b1, 8'd2,  32'h0000_2222, CHUNK_TWO,   1'b0, 32'h0, 6'd0, 10'd0},
      // seed-only chunks, then a key whose first chunk carries no bytes
      '{1'b1, 1'b1, 8'hFF, 32'h0000_0000, CHUNK_NONE,  1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b1, 1'b0, 8'd3,  32'h0000_0001, CHUNK_NONE,  1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b0, 1'b0, 8'd0,  32'h0000_0000, 3'd6,        1'b0, 32'h0, 6'd0, 10'd0},
      '{1'b0, 1'b1, 8'h80, 32'hABCD_EF01, CHUNK_ONE,   1'b0, 32'h0, 6'd0, 10'd0}
   };

   key_hash_shard_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic logic [HASH_W-1:0] hash_round(input logic [HASH_W-1:0]        h,
                                                    input logic [HASH_W-1:0]        d,
                                                    input logic [CHUNK_BYTES_W-1:0] nb);
      logic [HASH_W-1:0]        x;
      logic [HASH_W-1:0]        t;
      logic [CHUNK_BYTES_W-1:0] n;
      n = (nb > CHUNK_FULL) ? CHUNK_FULL : nb;
      x = h;
      case (n)
         CHUNK_FULL: begin
            x = x + {16'h0000, d[15:0]};
            t = ({16'h0000, d[31:16]} << 11) ^ x;
            x = (x << 16) ^ t;
            x = x + (x >> 11);
         end
         CHUNK_THREE: begin
            x = x + {16'h0000, d[15:0]};
            x = x ^ (x << 16);
            x = x ^ ({{24{d[23]}}, d[23:16]} << 18);
            x = x + (x >> 11);
         end
         CHUNK_TWO: begin
            x = x + {16'h0000, d[15:0]};
            x = x ^ (x << 11);
            x = x + (x >> 17);
         end
         CHUNK_ONE: begin
            x = x + {{24{d[7]}}, d[7:0]};
            x = x ^ (x << 10);
            x = x + (x >> 1);
         end
         default: begin
            x = h;
         end
      endcase
      return x;
   endfunction

   function automatic logic [HASH_W-1:0] hash_scramble(input logic [HASH_W-1:0] h);
      logic [HASH_W-1:0] x;
      x = h ^ (h << 3);
      x = x + (x >> 5);
      x = x ^ (x << 4);
      x = x + (x >> 17);
      x = x ^ (x << 25);
      x = x + (x >> 6);
      return x;
   endfunction

   task automatic track_chunk(input req_word_type w, input logic typed,
                              input rsp_word_type typed_shard);
      rsp_word_type      shard;
      logic [HASH_W-1:0] h;
      int unsigned       nc;
      int unsigned       ns;
      if (w.first_chunk) begin
         key_hash     = {24'h0, w.key_length};
         key_is_empty = (w.key_length == 0);
      end
      if (!key_is_empty) begin
         key_hash = hash_round(key_hash, w.chunk_data, w.chunk_bytes);
      end
      if (w.last_chunk) begin
         h  = key_is_empty ? '0 : hash_scramble(key_hash);
         nc = (cfg_cpu == 0) ? 1 : (cfg_cpu > CPU_COUNT_MAX) ? CPU_COUNT_MAX : cfg_cpu;
         ns = (cfg_slice == 0) ? 1 : (cfg_slice > SLICE_COUNT_MAX) ? SLICE_COUNT_MAX : cfg_slice;
         shard.hash_value  = h;
         shard.cpu_index   = CPU_IDX_W'(h % nc);
         shard.slice_index = SLICE_IDX_W'((h / nc) % ns);
         pending_shards.insert(pending_shards.size(), typed ? typed_shard : shard);
      end
   endtask

   task automatic send_chunk(input req_word_type w, input logic typed,
                             input rsp_word_type typed_shard);
      logic [63:0] noise;
      while ($urandom_range(99) < send_gap_pct) begin
         noise     = {$urandom, $urandom};
         req_valid <= 1'b0;
         req_word  <= noise[$bits(req_word_type)-1:0];
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      track_chunk(w, typed, typed_shard);
   endtask

   task automatic send_random_key(output int sent);
      req_word_type w;
      int unsigned  len;
      int unsigned  chunks;
      int unsigned  pick;
      pick = $urandom_range(99);
      sent = 0;
      if (pick < 12) begin
         w.first_chunk = 1'($urandom_range(1));
         w.last_chunk  = 1'($urandom_range(1));
         w.key_length  = KEY_LEN_W'($urandom);
         w.chunk_data  = $urandom;
         w.chunk_bytes = CHUNK_BYTES_W'($urandom_range(7));
         send_chunk(w, 1'b0, '0);
         sent = 1;
      end else begin
         len    = (pick < 17) ? $urandom_range(MAX_KEY_LEN, 32) : $urandom_range(16, 0);
         chunks = (len == 0) ? 1 : (len + 3) / 4;
         for (int i = 0; i < chunks; i++) begin
            w.first_chunk = (i == 0);
            w.last_chunk  = (i == chunks - 1);
            w.key_length  = (i == 0) ? KEY_LEN_W'(len) : KEY_LEN_W'($urandom);
            w.chunk_data  = $urandom;
            if (len == 0)
               w.chunk_bytes = CHUNK_BYTES_W'($urandom_range(7));
            else if (w.last_chunk && (len % 4) != 0)
               w.chunk_bytes = CHUNK_BYTES_W'(len % 4);
            else
               w.chunk_bytes = CHUNK_FULL;
            send_chunk(w, 1'b0, '0);
            sent++;
         end
      end
   endtask

   task automatic csr_access(input logic wr, input logic idx,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= CSR_ADDR_W'(idx) << CSR_IDX_BIT;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata        = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_count(input logic idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] stored;
      stored = (idx == REG_CPU_COUNT) ? (value & ((32'd1 << CPU_W) - 1))
                                      : (value & ((32'd1 << SLICE_W) - 1));
      csr_access(1'b1, idx, value, readback);
      csr_access(1'b0, idx, '0, readback);
      if (idx == REG_CPU_COUNT)
         cfg_cpu = stored[CPU_W-1:0];
      else
         cfg_slice = stored[SLICE_W-1:0];
      if (readback !== stored) begin
         error_count++;
         if (error_count <= 10)
            $display("tb: count reg %0d readback: expected %h, got %h", idx, stored, readback);
      end
   endtask

   task automatic drain_and_settle();
      while (pending_shards.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin : result_check
      rsp_word_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_gap_pct);
         if (rsp_valid && rsp_ready) begin
            if (pending_shards.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("tb: result word with none expected: hash %h cpu %0d slice %0d",
                           rsp_word.hash_value, rsp_word.cpu_index, rsp_word.slice_index);
            end else begin
               want = pending_shards.pop_front();
               if (rsp_word.hash_value !== want.hash_value ||
                   rsp_word.cpu_index !== want.cpu_index ||
                   rsp_word.slice_index !== want.slice_index) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("tb: result mismatch: expected hash %h cpu %0d slice %0d, %s",
                              want.hash_value, want.cpu_index, want.slice_index,
                              $sformatf("got hash %h cpu %0d slice %0d", rsp_word.hash_value,
                                        rsp_word.cpu_index, rsp_word.slice_index));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      req_word_type          w;
      rsp_word_type          fixed;
      logic [CSR_DATA_W-1:0] cpu_word;
      logic [CSR_DATA_W-1:0] slice_word;
      int                    phase_words;
      int                    sent;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      send_gap_pct = 22;
      rsp_gap_pct  = 68;

      for (int r = 0; r < N_PROBES; r++) begin
         w.first_chunk     = probe_rows[r].first;
         w.last_chunk      = probe_rows[r].last;
         w.key_length      = probe_rows[r].len;
         w.chunk_data      = probe_rows[r].data;
         w.chunk_bytes     = probe_rows[r].nbytes;
         fixed.hash_value  = probe_rows[r].hash;
         fixed.cpu_index   = probe_rows[r].cpu;
         fixed.slice_index = probe_rows[r].slice;
         send_chunk(w, probe_rows[r].typed, fixed);
      end
      req_valid <= 1'b0;

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_and_settle();
         case (phase)
            0: begin cpu_word = 64;  slice_word = 1024; end
            1: begin cpu_word = 0;   slice_word = 0;    end
            2: begin cpu_word = 127; slice_word = 2047; end
            3: begin cpu_word = 5;   slice_word = 1000; end
            4: begin
               cpu_word   = $urandom_range(CPU_COUNT_MAX, 1);
               slice_word = $urandom_range(SLICE_COUNT_MAX, 1);
            end
            default: begin cpu_word = $urandom; slice_word = $urandom; end
         endcase
         program_count(REG_CPU_COUNT, cpu_word);
         program_count(REG_SLICE_COUNT, slice_word);
         if (phase < 2) begin
            send_gap_pct = 22;
            rsp_gap_pct  = 68;
         end else if (phase < 4) begin
            send_gap_pct = 68;
            rsp_gap_pct  = 22;
         end else begin
            send_gap_pct = 0;
            rsp_gap_pct  = 0;
         end
         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            send_random_key(sent);
            phase_words += sent;
         end
         req_valid <= 1'b0;
      end

      drain_and_settle();
      if (error_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
